[design/mdt_pkg.sv]
// shared types, constants and helpers of the manhattan distance transform unit
package mdt_pkg;

  localparam int unsigned DIST_W    = 9;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PW      = 1;
  localparam int unsigned Q_CW      = 2;

  localparam logic [DIST_W-1:0]    DIST_MAX = 9'd511;
  localparam logic [CFG_W-1:0]     CFG_SIZE_RESET = 9'd256;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic                 CMD_WRITE = 1'b0;
  localparam logic                 CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_RANGE
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FWD_RD,
    ST_FWD_WR,
    ST_BWD_RD,
    ST_BWD_WR,
    ST_RD_DATA
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               pixel;
  } mdt_item_t;

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] x);
    return (x == DIST_MAX) ? DIST_MAX : x + 9'd1;
  endfunction

  function automatic logic [DIST_W-1:0] min3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

[design/mdt_front.sv]
// front end: accepts input transfers, range checks and classifies them
module mdt_front (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [7:0]                 row_i,
  input  logic [7:0]                 col_i,
  input  logic                       pixel_i,
  input  logic [8:0]                 eff_rows_i,
  input  logic [8:0]                 eff_cols_i,
  input  logic                       clearing_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output mdt_pkg::mdt_item_t         item_o
);
  import mdt_pkg::*;

  logic in_window;
  logic accept;

  assign in_window  = ({1'b0, row_i} < eff_rows_i) && ({1'b0, col_i} < eff_cols_i);
  assign in_stall_o = clearing_i || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_o.row   = row_i;
    item_o.col   = col_i;
    item_o.pixel = pixel_i;
    push_o       = 1'b0;
    if (command_i == CMD_READ) begin
      item_o.op = in_window ? OP_READ : OP_RANGE;
      push_o    = accept;
    end else begin
      // out-of-range pixel writes are dropped here
      item_o.op = OP_WRITE;
      push_o    = accept && in_window;
    end
  end

endmodule

[design/mdt_queue.sv]
// two-entry queue between the front end and the transform engine
module mdt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mdt_pkg::mdt_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output mdt_pkg::mdt_item_t head_o
);
  import mdt_pkg::*;

  mdt_item_t             ent_q [Q_DEPTH];
  logic [Q_PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [Q_PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o       = (cnt_q == Q_CW'(Q_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = ent_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[design/mdt_back.sv]
// transform engine: pixel and distance rams, raster passes, reads and result register
module mdt_back #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [8:0]         eff_rows_i,
  input  logic [8:0]         eff_cols_i,
  input  logic               cfg_upd_i,
  input  logic               head_valid_i,
  input  mdt_pkg::mdt_item_t head_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [8:0]         distance_o,
  output logic               no_source_o,
  output logic               out_of_range_o
);
  import mdt_pkg::*;

  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = 1 << AW;

  logic              pix_mem  [DEPTH];
  logic [DIST_W-1:0] dist_mem [DEPTH];

  state_e            state_q, state_d;
  logic [RW-1:0]     r_q, r_d;
  logic [CW-1:0]     c_q, c_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              changed_q, changed_d;
  logic              any_q, any_d;
  logic [DIST_W-1:0] nb_q, nb_d;
  logic              out_valid_q, out_valid_d;
  logic [DIST_W-1:0] dist_out_q, dist_out_d;
  logic              nosrc_q, nosrc_d;
  logic              oor_q, oor_d;

  logic              pix_we, pix_wdata, pix_rd_q;
  logic [AW-1:0]     pix_waddr, pix_raddr;
  logic              dist_we;
  logic [AW-1:0]     dist_waddr, dist_raddr_a, dist_raddr_b;
  logic [DIST_W-1:0] dist_wdata, dist_a_q, dist_b_q;

  logic [RW-1:0]     last_r;
  logic [CW-1:0]     last_c;
  logic [AW-1:0]     head_addr;
  logic              last_cell_fwd, last_cell_bwd;
  logic [DIST_W-1:0] fwd_d, bwd_d;

  assign last_r    = RW'(eff_rows_i - 9'd1);
  assign last_c    = CW'(eff_cols_i - 9'd1);
  assign head_addr = {RW'(head_i.row), CW'(head_i.col)};

  assign last_cell_fwd = (r_q == last_r) && (c_q == last_c);
  assign last_cell_bwd = (r_q == '0) && (c_q == '0);

  assign fwd_d = min3(pix_rd_q ? '0 : DIST_MAX,
                      (r_q != '0) ? sat_inc(dist_a_q) : DIST_MAX,
                      (c_q != '0) ? sat_inc(nb_q) : DIST_MAX);
  assign bwd_d = min3(dist_a_q,
                      (r_q != last_r) ? sat_inc(dist_b_q) : DIST_MAX,
                      (c_q != last_c) ? sat_inc(nb_q) : DIST_MAX);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (head_valid_i && head_i.op == OP_READ) begin
          if (changed_q) begin
            state_d = ST_FWD_RD;
          end else if (!out_valid_q) begin
            state_d = ST_RD_DATA;
          end
        end
      end
      ST_FWD_RD: state_d = ST_FWD_WR;
      ST_FWD_WR: begin
        state_d = last_cell_fwd ? ST_BWD_RD : ST_FWD_RD;
      end
      ST_BWD_RD: state_d = ST_BWD_WR;
      ST_BWD_WR: begin
        state_d = last_cell_bwd ? ST_IDLE : ST_BWD_RD;
      end
      ST_RD_DATA: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop_o        = 1'b0;
    r_d          = r_q;
    c_d          = c_q;
    clr_d        = clr_q;
    changed_d    = changed_q || cfg_upd_i;
    any_d        = any_q;
    nb_d         = nb_q;
    out_valid_d  = out_valid_q && out_stall_i;
    dist_out_d   = dist_out_q;
    nosrc_d      = nosrc_q;
    oor_d        = oor_q;
    pix_we       = 1'b0;
    pix_waddr    = head_addr;
    pix_wdata    = head_i.pixel;
    pix_raddr    = {r_q, c_q};
    dist_we      = 1'b0;
    dist_waddr   = {r_q, c_q};
    dist_wdata   = fwd_d;
    dist_raddr_a = {r_q, c_q};
    dist_raddr_b = {r_q + 1'b1, c_q};
    case (state_q)
      ST_CLEAR: begin
        pix_we    = 1'b1;
        pix_waddr = clr_q;
        pix_wdata = 1'b0;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_i.op)
            OP_WRITE: begin
              pop_o     = 1'b1;
              pix_we    = 1'b1;
              changed_d = 1'b1;
            end
            OP_RANGE: begin
              if (!out_valid_q) begin
                pop_o       = 1'b1;
                out_valid_d = 1'b1;
                dist_out_d  = '0;
                nosrc_d     = 1'b0;
                oor_d       = 1'b1;
              end
            end
            OP_READ: begin
              if (changed_q) begin
                r_d   = '0;
                c_d   = '0;
                any_d = 1'b0;
              end else if (!out_valid_q) begin
                pop_o        = 1'b1;
                dist_raddr_a = head_addr;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FWD_RD: begin
        dist_raddr_a = {r_q - 1'b1, c_q};
      end
      ST_FWD_WR: begin
        dist_we    = 1'b1;
        dist_wdata = fwd_d;
        nb_d       = fwd_d;
        any_d      = any_q || pix_rd_q;
        if (c_q == last_c) begin
          if (r_q == last_r) begin
            c_d = last_c;
          end else begin
            c_d = '0;
            r_d = r_q + 1'b1;
          end
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_BWD_RD: ;
      ST_BWD_WR: begin
        dist_we    = 1'b1;
        dist_wdata = bwd_d;
        nb_d       = bwd_d;
        if (c_q == '0) begin
          if (r_q == '0) begin
            changed_d = 1'b0;
          end else begin
            c_d = last_c;
            r_d = r_q - 1'b1;
          end
        end else begin
          c_d = c_q - 1'b1;
        end
      end
      ST_RD_DATA: begin
        out_valid_d = 1'b1;
        dist_out_d  = any_q ? dist_a_q : '0;
        nosrc_d     = !any_q;
        oor_d       = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      r_q         <= '0;
      c_q         <= '0;
      clr_q       <= '0;
      changed_q   <= 1'b1;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      c_q         <= c_d;
      clr_q       <= clr_d;
      changed_q   <= changed_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_q       <= nb_d;
    dist_out_q <= dist_out_d;
    nosrc_q    <= nosrc_d;
    oor_q      <= oor_d;
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[pix_waddr] <= pix_wdata;
    end
    pix_rd_q <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_a_q <= dist_mem[dist_raddr_a];
    dist_b_q <= dist_mem[dist_raddr_b];
  end

  assign clearing_o     = (state_q == ST_CLEAR);
  assign out_valid_o    = out_valid_q;
  assign distance_o     = dist_out_q;
  assign no_source_o    = nosrc_q;
  assign out_of_range_o = oor_q;

endmodule

[design/manhattan_distance_transform_unit.sv]
// top level of the manhattan (l1) distance transform unit
// After reset the pixel ram is cleared one cell per cycle, all 2**(RW+CW) cells with RW and CW
// the address bits of MAX_ROWS and MAX_COLS (65536 cells at 256 x 256); input stays stalled
// meanwhile, configuration writes are taken. A pixel write is taken straight from the idle
// state; an out-of-range read is answered from the idle state, an in-range read through a
// registered distance ram read and a data state, each only once the last result is taken.
// The first read after reset and after any pixel write or size change rebuilds the distance
// ram with a forward and a backward raster pass, each cell with a read state ahead of its
// write state for the registered ram read. A two-entry queue sits between the input checks
// and the engine.
module manhattan_distance_transform_unit #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] row_i,
  input  logic [7:0] col_i,
  input  logic       pixel_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [8:0] distance_o,
  output logic       no_source_o,
  output logic       out_of_range_o
);
  import mdt_pkg::*;

  logic [CFG_W-1:0] rows_q, rows_d;
  logic [CFG_W-1:0] cols_q, cols_d;
  logic [8:0]       eff_rows, eff_cols;
  logic             cfg_upd;
  logic             clearing;
  logic             q_full, q_push, q_pop, q_head_valid;
  mdt_item_t        q_item, q_head;

  assign cfg_upd = cfg_we_i && ((cfg_idx_i == REG_ROWS) || (cfg_idx_i == REG_COLS));

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_we_i && cfg_idx_i == REG_ROWS) rows_d = cfg_wdata_i;
    if (cfg_we_i && cfg_idx_i == REG_COLS) cols_d = cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_SIZE_RESET;
      cols_q <= CFG_SIZE_RESET;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  // window size clamped to the array, a zero size taken as one
  always_comb begin
    eff_rows = rows_q;
    eff_cols = cols_q;
    if (rows_q == '0) begin
      eff_rows = 9'd1;
    end else if (32'(rows_q) > MAX_ROWS) begin
      eff_rows = 9'(MAX_ROWS);
    end
    if (cols_q == '0) begin
      eff_cols = 9'd1;
    end else if (32'(cols_q) > MAX_COLS) begin
      eff_cols = 9'(MAX_COLS);
    end
  end

  mdt_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .pixel_i    (pixel_i),
    .eff_rows_i (eff_rows),
    .eff_cols_i (eff_cols),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .item_o     (q_item)
  );

  mdt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .item_i       (q_item),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  mdt_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .eff_rows_i     (eff_rows),
    .eff_cols_i     (eff_cols),
    .cfg_upd_i      (cfg_upd),
    .head_valid_i   (q_head_valid),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .distance_o     (distance_o),
    .no_source_o    (no_source_o),
    .out_of_range_o (out_of_range_o)
  );

  a_range_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> distance_o == '0 && !no_source_o)
    else $error("out-of-range result carries distance or no-source flag");

  a_nosrc_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_source_o |-> distance_o == '0)
    else $error("no-source result carries a distance");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("engine popped an empty queue");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full && !clearing)
    else $error("queue push while full or clearing");

endmodule
